FILE: hdl/dcf_pkg.sv
`default_nettype none

package dcf_pkg;

   localparam int unsigned TAPS_DEFAULT = 8;
   localparam int unsigned NCOEF        = 8;

   localparam int unsigned SAMPLE_W = 16;
   localparam int unsigned COEF_W   = 16;
   localparam int unsigned PROD_W   = 2 * SAMPLE_W;
   localparam int unsigned PAIR_W   = PROD_W + 1;
   localparam int unsigned SUM_W    = 35;

   localparam int unsigned CSR_INDEX_W = 4;
   localparam int unsigned CSR_DATA_W  = 2 * COEF_W;

   localparam int unsigned REQ_TDATA_W = 2 * SAMPLE_W;
   localparam int unsigned RSP_FIELD_W = 2 * SUM_W;
   localparam int unsigned RSP_TDATA_W = ((RSP_FIELD_W + 7) / 8) * 8;

   // load enables for the arithmetic stages
   typedef struct packed {
      logic load_prod;
      logic load_pair;
      logic load_sum;
   } pipe_ctrl_type;

endpackage

`default_nettype wire

FILE: hdl/dual_channel_fir_filter.sv
// dual channel fir filter: two independent real fir filters, i and q, over
// one i/q sample stream with up to eight taps per channel.
// req channel: one transaction carries one sample pair, sample_i in
//    req_tdata[15:0] and sample_q in req_tdata[31:16], signed q1.15.
// rsp channel: one transaction per sample, out_i in rsp_tdata[34:0] and
//    out_q in rsp_tdata[69:35], full precision signed q5.30.
// csr channel: csr_index selects coefficient pair 0..7, csr_data bits 31:16
//    hold the i coefficient and bits 15:0 the q coefficient; other indices
//    are ignored. write only while no sample is in flight.
// path: a sample taken into the tap line goes on to rsp through the
//    product, pair sum and output registers in turn.
// throughput: one sample per clock while rsp_tready is high; every stage
//    holds its own item; a sample is taken whenever some stage ahead has room.
// reset clears the delay lines, the coefficients and all valid flags.
// when rsp_tready is low the output register holds its result and the
//    stages behind it fill up in turn; req_tready drops once all are full.
`default_nettype none

module dual_channel_fir_filter
   import dcf_pkg::*;
#(
   parameter int unsigned TAPS = TAPS_DEFAULT
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_tvalid,
   output logic                               req_tready,
   input  wire logic [REQ_TDATA_W-1:0]        req_tdata,  // sample_i, sample_q
   output logic                               rsp_tvalid,
   input  wire logic                          rsp_tready,
   output logic [RSP_TDATA_W-1:0]             rsp_tdata,  // out_i, out_q, zero pad
   input  wire logic                          csr_valid,
   output logic                               csr_ready,
   input  wire logic [CSR_INDEX_W-1:0]        csr_index,
   input  wire logic [CSR_DATA_W-1:0]         csr_data
);

   logic tap_valid_ff, tap_valid_in;
   logic prod_valid_ff, prod_valid_in;
   logic pair_valid_ff, pair_valid_in;
   logic out_valid_ff, out_valid_in;

   logic out_ready, pair_ready, prod_ready, tap_ready;
   logic req_accept;
   pipe_ctrl_type ctrl;

   logic signed [COEF_W-1:0]   coef_i [NCOEF];
   logic signed [COEF_W-1:0]   coef_q [NCOEF];
   logic signed [SAMPLE_W-1:0] taps_i [TAPS];
   logic signed [SAMPLE_W-1:0] taps_q [TAPS];
   logic signed [SUM_W-1:0]    sum_i;
   logic signed [SUM_W-1:0]    sum_q;

   assign out_ready  = !out_valid_ff  || rsp_tready;
   assign pair_ready = !pair_valid_ff || out_ready;
   assign prod_ready = !prod_valid_ff || pair_ready;
   assign tap_ready  = !tap_valid_ff  || prod_ready;

   assign req_tready = tap_ready;
   assign req_accept = req_tvalid && tap_ready;
   assign csr_ready  = 1'b1;

   assign ctrl.load_prod = tap_valid_ff  && prod_ready;
   assign ctrl.load_pair = prod_valid_ff && pair_ready;
   assign ctrl.load_sum  = pair_valid_ff && out_ready;

   always_comb begin
      tap_valid_in  = tap_ready  ? req_tvalid    : tap_valid_ff;
      prod_valid_in = prod_ready ? tap_valid_ff  : prod_valid_ff;
      pair_valid_in = pair_ready ? prod_valid_ff : pair_valid_ff;
      out_valid_in  = out_ready  ? pair_valid_ff : out_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tap_valid_ff  <= 1'b0;
         prod_valid_ff <= 1'b0;
         pair_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         tap_valid_ff  <= tap_valid_in;
         prod_valid_ff <= prod_valid_in;
         pair_valid_ff <= pair_valid_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   dcf_coef_regs u_coef_regs (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .coef_i    (coef_i),
      .coef_q    (coef_q)
   );

   dcf_tap_line #(
      .TAPS (TAPS)
   ) u_tap_line (
      .clock    (clock),
      .reset    (reset),
      .shift_en (req_accept),
      .sample_i (signed'(req_tdata[SAMPLE_W-1:0])),
      .sample_q (signed'(req_tdata[REQ_TDATA_W-1:SAMPLE_W])),
      .taps_i   (taps_i),
      .taps_q   (taps_q)
   );

   dcf_fir_core #(
      .TAPS (TAPS)
   ) u_fir_core_i (
      .clock (clock),
      .ctrl  (ctrl),
      .taps  (taps_i),
      .coef  (coef_i),
      .sum   (sum_i)
   );

   dcf_fir_core #(
      .TAPS (TAPS)
   ) u_fir_core_q (
      .clock (clock),
      .ctrl  (ctrl),
      .taps  (taps_q),
      .coef  (coef_q),
      .sum   (sum_q)
   );

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {(RSP_TDATA_W - RSP_FIELD_W)'(0), sum_q, sum_i};

`ifndef SYNTHESIS
   a_reset_empties: assert property (@(posedge clock)
      reset |=> !tap_valid_ff && !prod_valid_ff && !pair_valid_ff && !out_valid_ff)
      else $error("pipeline not empty after reset");

   a_accept_lands: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> tap_valid_ff)
      else $error("accepted sample not held in tap stage");

   a_prod_moves: assert property (@(posedge clock) disable iff (reset)
      prod_valid_ff && !pair_valid_ff |=> pair_valid_ff)
      else $error("product stage did not advance into empty pair stage");

   a_pair_moves: assert property (@(posedge clock) disable iff (reset)
      pair_valid_ff && !out_valid_ff |=> out_valid_ff)
      else $error("pair stage did not advance into empty output register");
`endif

endmodule

`default_nettype wire

FILE: hdl/dcf_coef_regs.sv
`default_nettype none

module dcf_coef_regs
   import dcf_pkg::*;
(
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          csr_valid,
   input  wire logic [CSR_INDEX_W-1:0]        csr_index,
   input  wire logic [CSR_DATA_W-1:0]         csr_data,
   output logic signed [COEF_W-1:0]           coef_i [NCOEF],
   output logic signed [COEF_W-1:0]           coef_q [NCOEF]
);

   logic [CSR_DATA_W-1:0] coef_pair_ff [NCOEF];
   logic [CSR_DATA_W-1:0] coef_pair_in [NCOEF];

   // writes beyond the register list fall through untouched
   always_comb begin
      for (int k = 0; k < NCOEF; k++) begin
         coef_pair_in[k] = coef_pair_ff[k];
         if (csr_valid && (csr_index == CSR_INDEX_W'(k))) begin
            coef_pair_in[k] = csr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < NCOEF; k++) begin
            coef_pair_ff[k] <= '0;
         end
      end else begin
         coef_pair_ff <= coef_pair_in;
      end
   end

   always_comb begin
      for (int k = 0; k < NCOEF; k++) begin
         coef_i[k] = signed'(coef_pair_ff[k][CSR_DATA_W-1:COEF_W]);
         coef_q[k] = signed'(coef_pair_ff[k][COEF_W-1:0]);
      end
   end

endmodule

`default_nettype wire

FILE: hdl/dcf_tap_line.sv
`default_nettype none

module dcf_tap_line
   import dcf_pkg::*;
#(
   parameter int unsigned TAPS = TAPS_DEFAULT
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          shift_en,
   input  wire logic signed [SAMPLE_W-1:0]    sample_i,
   input  wire logic signed [SAMPLE_W-1:0]    sample_q,
   output logic signed [SAMPLE_W-1:0]         taps_i [TAPS],
   output logic signed [SAMPLE_W-1:0]         taps_q [TAPS]
);

   logic signed [SAMPLE_W-1:0] line_i_ff [TAPS];
   logic signed [SAMPLE_W-1:0] line_q_ff [TAPS];

   // newest sample at tap 0
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int t = 0; t < TAPS; t++) begin
            line_i_ff[t] <= '0;
            line_q_ff[t] <= '0;
         end
      end else if (shift_en) begin
         for (int t = 1; t < TAPS; t++) begin
            line_i_ff[t] <= line_i_ff[t-1];
            line_q_ff[t] <= line_q_ff[t-1];
         end
         line_i_ff[0] <= sample_i;
         line_q_ff[0] <= sample_q;
      end
   end

   assign taps_i = line_i_ff;
   assign taps_q = line_q_ff;

endmodule

`default_nettype wire

FILE: hdl/dcf_fir_core.sv
`default_nettype none

module dcf_fir_core
   import dcf_pkg::*;
#(
   parameter int unsigned TAPS = TAPS_DEFAULT
) (
   input  wire logic                          clock,
   input  wire pipe_ctrl_type                 ctrl,
   input  wire logic signed [SAMPLE_W-1:0]    taps [TAPS],
   input  wire logic signed [COEF_W-1:0]      coef [NCOEF],
   output logic signed [SUM_W-1:0]            sum
);

   localparam int unsigned NPAIR = (TAPS + 1) / 2;

   logic signed [PROD_W-1:0] prod_ff [TAPS];
   logic signed [PROD_W-1:0] prod_in [TAPS];
   logic signed [PAIR_W-1:0] pair_ff [NPAIR];
   logic signed [PAIR_W-1:0] pair_in [NPAIR];
   logic signed [SUM_W-1:0]  sum_ff;
   logic signed [SUM_W-1:0]  sum_in;

   always_comb begin
      for (int t = 0; t < TAPS; t++) begin
         prod_in[t] = coef[t] * taps[t];
      end
   end

   // odd tap count leaves the last pair with one product
   always_comb begin
      for (int p = 0; p < NPAIR; p++) begin
         if ((2 * p + 1) < TAPS) begin
            pair_in[p] = PAIR_W'(prod_ff[2*p]) + PAIR_W'(prod_ff[2*p+1]);
         end else begin
            pair_in[p] = PAIR_W'(prod_ff[2*p]);
         end
      end
   end

   always_comb begin
      sum_in = '0;
      for (int p = 0; p < NPAIR; p++) begin
         sum_in = sum_in + SUM_W'(pair_ff[p]);
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.load_prod) begin
         prod_ff <= prod_in;
      end
      if (ctrl.load_pair) begin
         pair_ff <= pair_in;
      end
      if (ctrl.load_sum) begin
         sum_ff <= sum_in;
      end
   end

   assign sum = sum_ff;

endmodule

`default_nettype wire
